>>> src/coordinate_system_converter_macros.svh
// Assertion macros shared by the converter RTL.
`ifndef COORDINATE_SYSTEM_CONVERTER_MACROS_SVH
`define COORDINATE_SYSTEM_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/csc_pkg.sv
// Shared constants, types and functions of the coordinate system converter.
package csc_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int STEPS_MAX        = 30;

    localparam int VAL_W   = 36;             // lengths and angles between stages
    localparam int GUARD   = 8;              // guard bits inside the CORDIC
    localparam int CORE_W  = 48;             // CORDIC datapath width
    localparam int GAIN_W  = 25;             // signed width of the gain constant
    localparam int FRAC    = 24;             // fraction bits of the gain constant
    localparam int PROD_W  = CORE_W - GUARD + GAIN_W;

    localparam logic [2:0] OP_CART_SPH = 3'd0;
    localparam logic [2:0] OP_CART_CYL = 3'd1;
    localparam logic [2:0] OP_SPH_CART = 3'd2;
    localparam logic [2:0] OP_SPH_CYL  = 3'd3;
    localparam logic [2:0] OP_CYL_CART = 3'd4;
    localparam logic [2:0] OP_CYL_SPH  = 3'd5;

    localparam logic signed [VAL_W-1:0] ANG_PI      = 36'sd843314857;
    localparam logic signed [VAL_W-1:0] ANG_HALF_PI = 36'sd421657428;
    localparam logic signed [VAL_W-1:0] ANG_TWO_PI  = 36'sd1686629713;

    localparam logic signed [GAIN_W-1:0] INV_GAIN   = 25'sd10188014;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd8388608);

    // Sideband carried along with each request through both CORDIC passes.
    typedef struct packed {
        logic [2:0]              op;
        logic signed [31:0]      ca;
        logic signed [31:0]      cb;
        logic signed [31:0]      cc;
        logic signed [VAL_W-1:0] r0;    // first pass: magnitude or cosine term
        logic signed [VAL_W-1:0] r1;    // first pass: sine term
        logic signed [VAL_W-1:0] r2;    // first pass: angle
    } side_t;

    // atan(2^-i) in Q4.28
    function automatic logic signed [31:0] atan_q28(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:    v = 32'sd210828714;
            5'd1:    v = 32'sd124459457;
            5'd2:    v = 32'sd65760959;
            5'd3:    v = 32'sd33381290;
            5'd4:    v = 32'sd16755422;
            5'd5:    v = 32'sd8385879;
            5'd6:    v = 32'sd4193963;
            5'd7:    v = 32'sd2097109;
            5'd8:    v = 32'sd1048571;
            5'd9:    v = 32'sd524287;
            5'd10:   v = 32'sd262144;
            5'd11:   v = 32'sd131072;
            5'd12:   v = 32'sd65536;
            5'd13:   v = 32'sd32768;
            5'd14:   v = 32'sd16384;
            5'd15:   v = 32'sd8192;
            5'd16:   v = 32'sd4096;
            5'd17:   v = 32'sd2048;
            5'd18:   v = 32'sd1024;
            5'd19:   v = 32'sd512;
            5'd20:   v = 32'sd256;
            5'd21:   v = 32'sd128;
            5'd22:   v = 32'sd64;
            5'd23:   v = 32'sd32;
            5'd24:   v = 32'sd16;
            5'd25:   v = 32'sd8;
            5'd26:   v = 32'sd4;
            5'd27:   v = 32'sd2;
            5'd28:   v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // Clamp to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [VAL_W-1:0] v);
        logic signed [31:0] r;
        if (v > VAL_W'(64'sd2147483647)) begin
            r = 32'sh7fffffff;
        end
        else if (v < -VAL_W'(64'sd2147483648)) begin
            r = 32'sh80000000;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> src/csc_interfaces.sv
// Request and result stream interfaces of the coordinate system converter.
interface csc_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic signed [31:0] coord_a;
    logic signed [31:0] coord_b;
    logic signed [31:0] coord_c;

    modport source (output valid, op, coord_a, coord_b, coord_c, input ready);
    modport sink   (input valid, op, coord_a, coord_b, coord_c, output ready);
endinterface

interface csc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_a;
    logic signed [31:0] result_b;
    logic signed [31:0] result_c;

    modport source (output valid, result_a, result_b, result_c, input ready);
    modport sink   (input valid, result_a, result_b, result_c, output ready);
endinterface

>>> src/coordinate_system_converter.sv
// Top level of the coordinate system converter: two chained CORDIC passes.
//
//   channel  modport  payload                          request
//   in_ch    sink     op, coord_a, coord_b, coord_c    one point and conversion code
//   out_ch   source   result_a, result_b, result_c     one converted point
//
// Accepts one request per cycle while out_ch is not stalled; each request passes
// through two CORDIC passes of CORDIC_STEPS + 5 stages each and then the
// saturating output register.
// rst_n clears all valid bits asynchronously; payload registers are not reset.
// A stall on out_ch freezes the whole pipeline in place; in_ch.ready drops
// only while a result sits in the output register and out_ch is not ready.
`include "coordinate_system_converter_macros.svh"

module coordinate_system_converter #(
    parameter int CORDIC_STEPS = csc_pkg::CORDIC_STEPS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    csc_in_if.sink     in_ch,
    csc_out_if.source  out_ch
);

    localparam int VW = csc_pkg::VAL_W;

    logic advance;

    // pass 1 request
    logic                p1_in_rot;
    logic signed [VW-1:0] p1_in_x, p1_in_y;
    csc_pkg::side_t      p1_in_side;

    // pass 1 result
    logic                p1_valid;
    logic signed [VW-1:0] p1_x, p1_y, p1_ang;
    csc_pkg::side_t      p1_side;

    // pass 2 request
    logic                p2_in_rot;
    logic signed [VW-1:0] p2_in_x, p2_in_y;
    csc_pkg::side_t      p2_in_side;

    // pass 2 result
    logic                p2_valid;
    logic signed [VW-1:0] p2_x, p2_y, p2_ang;
    csc_pkg::side_t      p2_side;

    // output register
    logic                out_valid_reg;
    logic [2:0]          out_op_reg;
    logic signed [31:0]  res_a_reg, res_b_reg, res_c_reg;
    logic signed [VW-1:0] ra_next, rb_next, rc_next;

    // The pipeline moves as one; it holds only when a finished result waits.
    assign advance     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = advance;

    // First pass: vectoring for the Cartesian and cylinder-to-sphere forms,
    // rotation wherever an angle is turned back into lengths.
    always_comb
    begin
        p1_in_rot = 1'b0;
        p1_in_x   = VW'(in_ch.coord_a);
        p1_in_y   = VW'(in_ch.coord_b);
        case (in_ch.op)
            csc_pkg::OP_CART_SPH,
            csc_pkg::OP_CART_CYL:
            begin
                p1_in_rot = 1'b0;
            end
            csc_pkg::OP_SPH_CART,
            csc_pkg::OP_SPH_CYL:
            begin
                // radius turned by theta
                p1_in_rot = 1'b1;
                p1_in_y   = VW'(in_ch.coord_c);
            end
            csc_pkg::OP_CYL_CART:
            begin
                p1_in_rot = 1'b1;
            end
            csc_pkg::OP_CYL_SPH:
            begin
                // theta = atan2(rho, height)
                p1_in_x = VW'(in_ch.coord_c);
                p1_in_y = VW'(in_ch.coord_a);
            end
            default:
            begin
                p1_in_rot = 1'b0;
            end
        endcase
        p1_in_side.op = in_ch.op;
        p1_in_side.ca = in_ch.coord_a;
        p1_in_side.cb = in_ch.coord_b;
        p1_in_side.cc = in_ch.coord_c;
        p1_in_side.r0 = '0;
        p1_in_side.r1 = '0;
        p1_in_side.r2 = '0;
    end

    csc_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_pass1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (in_ch.valid),
        .in_rot    (p1_in_rot),
        .in_x      (p1_in_x),
        .in_y      (p1_in_y),
        .in_side   (p1_in_side),
        .out_valid (p1_valid),
        .out_x     (p1_x),
        .out_y     (p1_y),
        .out_ang   (p1_ang),
        .out_side  (p1_side)
    );

    // Second pass is used by the two full 3D conversions only; the unclamped
    // first-pass value feeds it directly.
    always_comb
    begin
        p2_in_rot = 1'b0;
        p2_in_x   = VW'(p1_side.cc);
        p2_in_y   = p1_x;
        if (p1_side.op == csc_pkg::OP_SPH_CART) begin
            // r*sin(theta) turned by phi
            p2_in_rot = 1'b1;
            p2_in_x   = p1_y;
            p2_in_y   = VW'(p1_side.cb);
        end
        p2_in_side    = p1_side;
        p2_in_side.r0 = p1_x;
        p2_in_side.r1 = p1_y;
        p2_in_side.r2 = p1_ang;
    end

    csc_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_pass2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (p1_valid),
        .in_rot    (p2_in_rot),
        .in_x      (p2_in_x),
        .in_y      (p2_in_y),
        .in_side   (p2_in_side),
        .out_valid (p2_valid),
        .out_x     (p2_x),
        .out_y     (p2_y),
        .out_ang   (p2_ang),
        .out_side  (p2_side)
    );

    // Pick each output from pass 1, pass 2 or the passed-through inputs.
    always_comb
    begin
        ra_next = '0;
        rb_next = '0;
        rc_next = '0;
        case (p2_side.op)
            csc_pkg::OP_CART_SPH:
            begin
                ra_next = p2_x;
                rb_next = p2_side.r2;
                rc_next = p2_ang;
            end
            csc_pkg::OP_CART_CYL:
            begin
                ra_next = p2_side.r0;
                rb_next = p2_side.r2;
                rc_next = VW'(p2_side.cc);
            end
            csc_pkg::OP_SPH_CART:
            begin
                ra_next = p2_x;
                rb_next = p2_y;
                rc_next = p2_side.r0;
            end
            csc_pkg::OP_SPH_CYL:
            begin
                ra_next = p2_side.r1;
                rb_next = VW'(p2_side.cb);
                rc_next = p2_side.r0;
            end
            csc_pkg::OP_CYL_CART:
            begin
                ra_next = p2_side.r0;
                rb_next = p2_side.r1;
                rc_next = VW'(p2_side.cc);
            end
            csc_pkg::OP_CYL_SPH:
            begin
                ra_next = p2_side.r0;
                rb_next = VW'(p2_side.cb);
                rc_next = p2_side.r2;
            end
            default:
            begin
                // unused codes give an all-zero result
                ra_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (advance) begin
            out_valid_reg <= p2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_op_reg <= p2_side.op;
            res_a_reg  <= csc_pkg::sat32(ra_next);
            res_b_reg  <= csc_pkg::sat32(rb_next);
            res_c_reg  <= csc_pkg::sat32(rc_next);
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.result_a = res_a_reg;
    assign out_ch.result_b = res_b_reg;
    assign out_ch.result_c = res_c_reg;

    // a held pipeline keeps its inner occupancy
    `CSC_ASSERT_NEXT(a_stall_holds, clk, rst_n, !advance, $stable(p1_valid) && $stable(p2_valid), "pipeline moved during stall")
    // unused codes come out as zeros
    `CSC_ASSERT_IMPL(a_unused_zero, clk, rst_n, out_valid_reg && (out_op_reg > csc_pkg::OP_CYL_SPH), (res_a_reg == 0) && (res_b_reg == 0) && (res_c_reg == 0), "unused code gave nonzero result")
    // a spherical radius is never negative
    `CSC_ASSERT_IMPL(a_radius_sign, clk, rst_n, out_valid_reg && (out_op_reg == csc_pkg::OP_CART_SPH), res_a_reg >= 0, "negative spherical radius")

endmodule

>>> src/csc_cordic.sv
// Pipelined CORDIC pass: vectoring or rotation chosen per request, gain compensated.
module csc_cordic #(
    parameter int STEPS = csc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic                                in_rot,
    input  logic signed [csc_pkg::VAL_W-1:0]    in_x,
    input  logic signed [csc_pkg::VAL_W-1:0]    in_y,
    input  csc_pkg::side_t                      in_side,
    output logic                                out_valid,
    output logic signed [csc_pkg::VAL_W-1:0]    out_x,
    output logic signed [csc_pkg::VAL_W-1:0]    out_y,
    output logic signed [csc_pkg::VAL_W-1:0]    out_ang,
    output csc_pkg::side_t                      out_side
);

    localparam int VW = csc_pkg::VAL_W;
    localparam int CW = csc_pkg::CORE_W;
    localparam int FW = CW - csc_pkg::GUARD;
    localparam int PW = csc_pkg::PROD_W;

    // angle wrap stage
    logic                w_valid_reg;
    logic                w_rot_reg;
    logic signed [VW-1:0] w_x_reg, w_y_reg, w_z_reg;
    csc_pkg::side_t      w_side_reg;
    logic signed [VW-1:0] z1, z2;

    // iteration stages; index 0 is the setup stage
    logic                it_valid_reg [0:STEPS];
    logic                it_rot_reg   [0:STEPS];
    logic                it_zero_reg  [0:STEPS];
    logic                it_neg_reg   [0:STEPS];
    logic signed [CW-1:0] it_x_reg    [0:STEPS];
    logic signed [CW-1:0] it_y_reg    [0:STEPS];
    logic signed [VW-1:0] it_z_reg    [0:STEPS];
    csc_pkg::side_t      it_side_reg  [0:STEPS];

    logic                it_valid_next [0:STEPS];
    logic                it_rot_next   [0:STEPS];
    logic                it_zero_next  [0:STEPS];
    logic                it_neg_next   [0:STEPS];
    logic signed [CW-1:0] it_x_next    [0:STEPS];
    logic signed [CW-1:0] it_y_next    [0:STEPS];
    logic signed [VW-1:0] it_z_next    [0:STEPS];
    csc_pkg::side_t      it_side_next  [0:STEPS];

    // sign fix and guard removal
    logic                f_valid_reg;
    logic signed [FW-1:0] f_x_reg, f_y_reg;
    logic signed [VW-1:0] f_ang_reg;
    csc_pkg::side_t      f_side_reg;
    logic signed [CW-1:0] fx_full, fy_full;

    // gain multiply
    logic                m_valid_reg;
    logic signed [PW-1:0] m_x_reg, m_y_reg;
    logic signed [VW-1:0] m_ang_reg;
    csc_pkg::side_t      m_side_reg;

    // result
    logic                o_valid_reg;
    logic signed [VW-1:0] o_x_reg, o_y_reg, o_ang_reg;
    csc_pkg::side_t      o_side_reg;

    // wrap into [-pi, pi], at most two turns for a 32-bit angle
    always_comb
    begin
        if (in_y > csc_pkg::ANG_PI) begin
            z1 = in_y - csc_pkg::ANG_TWO_PI;
        end
        else if (in_y < -csc_pkg::ANG_PI) begin
            z1 = in_y + csc_pkg::ANG_TWO_PI;
        end
        else begin
            z1 = in_y;
        end
        if (z1 > csc_pkg::ANG_PI) begin
            z2 = z1 - csc_pkg::ANG_TWO_PI;
        end
        else if (z1 < -csc_pkg::ANG_PI) begin
            z2 = z1 + csc_pkg::ANG_TWO_PI;
        end
        else begin
            z2 = z1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            w_valid_reg <= 1'b0;
        end
        else if (en) begin
            w_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            w_rot_reg  <= in_rot;
            w_x_reg    <= in_x;
            w_y_reg    <= in_y;
            w_z_reg    <= z2;
            w_side_reg <= in_side;
        end
    end

    // setup and micro-rotations feed the iteration registers
    always_comb
    begin
        logic signed [CW-1:0] xe, ye, nx, ny;
        logic d;
        // setup: fold by pi for rotation, quadrant swap for vectoring
        xe = CW'(w_x_reg);
        ye = CW'(w_y_reg);
        nx = xe;
        ny = ye;
        it_valid_next[0] = w_valid_reg;
        it_rot_next[0]   = w_rot_reg;
        it_side_next[0]  = w_side_reg;
        it_zero_next[0]  = 1'b0;
        it_neg_next[0]   = 1'b0;
        it_z_next[0]     = '0;
        if (w_rot_reg) begin
            ny = '0;
            if (w_z_reg > csc_pkg::ANG_HALF_PI) begin
                it_z_next[0] = w_z_reg - csc_pkg::ANG_PI;
                it_neg_next[0] = 1'b1;
            end
            else if (w_z_reg < -csc_pkg::ANG_HALF_PI) begin
                it_z_next[0] = w_z_reg + csc_pkg::ANG_PI;
                it_neg_next[0] = 1'b1;
            end
            else begin
                it_z_next[0] = w_z_reg;
            end
        end
        else begin
            it_zero_next[0] = (w_x_reg == '0) && (w_y_reg == '0);
            if (xe < 0) begin
                if (ye >= 0) begin
                    nx = ye;
                    ny = -xe;
                    it_z_next[0] = csc_pkg::ANG_HALF_PI;
                end
                else begin
                    nx = -ye;
                    ny = xe;
                    it_z_next[0] = -csc_pkg::ANG_HALF_PI;
                end
            end
        end
        it_x_next[0] = nx <<< csc_pkg::GUARD;
        it_y_next[0] = ny <<< csc_pkg::GUARD;

        // one micro-rotation per stage; d set means rotate counterclockwise
        for (int i = 0; i < STEPS; i++) begin
            d = it_rot_reg[i] ? (it_z_reg[i] >= 0) : (it_y_reg[i] < 0);
            it_valid_next[i+1] = it_valid_reg[i];
            it_rot_next[i+1]   = it_rot_reg[i];
            it_zero_next[i+1]  = it_zero_reg[i];
            it_neg_next[i+1]   = it_neg_reg[i];
            it_side_next[i+1]  = it_side_reg[i];
            if (d) begin
                it_x_next[i+1] = it_x_reg[i] - (it_y_reg[i] >>> i);
                it_y_next[i+1] = it_y_reg[i] + (it_x_reg[i] >>> i);
                it_z_next[i+1] = it_z_reg[i] - VW'(csc_pkg::atan_q28(5'(i)));
            end
            else begin
                it_x_next[i+1] = it_x_reg[i] + (it_y_reg[i] >>> i);
                it_y_next[i+1] = it_y_reg[i] - (it_x_reg[i] >>> i);
                it_z_next[i+1] = it_z_reg[i] + VW'(csc_pkg::atan_q28(5'(i)));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i <= STEPS; i++) begin
                it_valid_reg[i] <= 1'b0;
            end
        end
        else if (en) begin
            for (int i = 0; i <= STEPS; i++) begin
                it_valid_reg[i] <= it_valid_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            for (int i = 0; i <= STEPS; i++) begin
                it_rot_reg[i]  <= it_rot_next[i];
                it_zero_reg[i] <= it_zero_next[i];
                it_neg_reg[i]  <= it_neg_next[i];
                it_x_reg[i]    <= it_x_next[i];
                it_y_reg[i]    <= it_y_next[i];
                it_z_reg[i]    <= it_z_next[i];
                it_side_reg[i] <= it_side_next[i];
            end
        end
    end

    // zero vector and folded-angle sign
    always_comb
    begin
        if (it_zero_reg[STEPS]) begin
            fx_full = '0;
            fy_full = '0;
        end
        else if (it_neg_reg[STEPS]) begin
            fx_full = -it_x_reg[STEPS];
            fy_full = -it_y_reg[STEPS];
        end
        else begin
            fx_full = it_x_reg[STEPS];
            fy_full = it_y_reg[STEPS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            f_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (en) begin
            f_valid_reg <= it_valid_reg[STEPS];
            m_valid_reg <= f_valid_reg;
            o_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            f_x_reg    <= FW'(fx_full >>> csc_pkg::GUARD);
            f_y_reg    <= FW'(fy_full >>> csc_pkg::GUARD);
            f_ang_reg  <= it_zero_reg[STEPS] ? '0 : it_z_reg[STEPS];
            f_side_reg <= it_side_reg[STEPS];

            m_x_reg    <= PW'(f_x_reg) * PW'(csc_pkg::INV_GAIN) + csc_pkg::ROUND_HALF;
            m_y_reg    <= PW'(f_y_reg) * PW'(csc_pkg::INV_GAIN) + csc_pkg::ROUND_HALF;
            m_ang_reg  <= f_ang_reg;
            m_side_reg <= f_side_reg;

            o_x_reg    <= VW'(m_x_reg >>> csc_pkg::FRAC);
            o_y_reg    <= VW'(m_y_reg >>> csc_pkg::FRAC);
            o_ang_reg  <= m_ang_reg;
            o_side_reg <= m_side_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_x     = o_x_reg;
    assign out_y     = o_y_reg;
    assign out_ang   = o_ang_reg;
    assign out_side  = o_side_reg;

endmodule
